FILE: design/artdmx_pkg.sv
// Shared types and constants for the Art-Net DMX packet parser.
package artdmx_pkg;

    localparam int HDR_LEN = 18;

    localparam logic [7:0] OPCODE_LO = 8'h00;
    localparam logic [7:0] OPCODE_HI = 8'h50;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_UNIVERSE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_ID   = 3'd2,
        ST_OPCODE   = 3'd3,
        ST_FILTERED = 3'd4
    } t_status;

    typedef struct packed {
        logic        slot_valid;
        logic [8:0]  slot_index;
        logic [7:0]  slot_value;
        logic        frame_end;
        t_status     status;
        logic [15:0] universe;
        logic [7:0]  sequence_num;
        logic [7:0]  physical;
        logic [9:0]  slot_count;
        logic        truncated;
    } t_result;

    // "Art-Net" identifier, bytes 0 to 6
    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h41;
            3'd1:    v = 8'h72;
            3'd2:    v = 8'h74;
            3'd3:    v = 8'h2D;
            3'd4:    v = 8'h4E;
            3'd5:    v = 8'h65;
            3'd6:    v = 8'h74;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: design/artdmx_parse.sv
// Header decode, field latching and slot/status result build for one byte.
module artdmx_parse #(
    parameter int MAX_SLOTS = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_filt_en,
    input  logic [15:0]          i_filt_uni,
    output logic                 o_produce,
    output artdmx_pkg::t_result  o_result
);

    localparam int POS_W = $clog2(artdmx_pkg::HDR_LEN + MAX_SLOTS + 1);
    localparam logic [POS_W-1:0] P_HDR   = POS_W'(artdmx_pkg::HDR_LEN);
    localparam logic [POS_W-1:0] P_HDR_M = POS_W'(artdmx_pkg::HDR_LEN - 1);
    localparam logic [POS_W-1:0] P_LIMIT = POS_W'(artdmx_pkg::HDR_LEN + MAX_SLOTS);
    localparam logic [POS_W-1:0] P_MAX   = POS_W'(MAX_SLOTS);
    localparam logic [POS_W-1:0] P_ID    = POS_W'(7);
    localparam logic [POS_W-1:0] P_OP0   = POS_W'(8);
    localparam logic [POS_W-1:0] P_OP1   = POS_W'(9);
    localparam logic [POS_W-1:0] P_SEQ   = POS_W'(12);
    localparam logic [POS_W-1:0] P_PHY   = POS_W'(13);
    localparam logic [POS_W-1:0] P_UNI0  = POS_W'(14);
    localparam logic [POS_W-1:0] P_UNI1  = POS_W'(15);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_hdr_ok, n_hdr_ok;
    logic             r_op_ok, n_op_ok;
    logic             r_ovf, n_ovf;
    logic [15:0]      r_uni, n_uni;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_phy, n_phy;

    logic             passes;
    logic             in_data;
    logic             emit;
    logic [POS_W-1:0] slot_pos;
    logic [POS_W-1:0] cnt_raw;
    logic [POS_W-1:0] cnt_sat;
    artdmx_pkg::t_status status;

    always_comb begin
        n_hdr_ok = r_hdr_ok;
        if (r_pos < P_ID && i_byte != artdmx_pkg::ident_byte(r_pos[2:0])) begin
            n_hdr_ok = 1'b0;
        end
        n_op_ok = r_op_ok;
        if ((r_pos == P_OP0 && i_byte != artdmx_pkg::OPCODE_LO) ||
            (r_pos == P_OP1 && i_byte != artdmx_pkg::OPCODE_HI)) begin
            n_op_ok = 1'b0;
        end
        n_seq = (r_pos == P_SEQ) ? i_byte : r_seq;
        n_phy = (r_pos == P_PHY) ? i_byte : r_phy;
        n_uni = r_uni;
        if (r_pos == P_UNI0) begin
            n_uni[7:0] = i_byte;
        end
        if (r_pos == P_UNI1) begin
            n_uni[15:8] = i_byte;
        end

        passes   = !i_filt_en || (n_uni == i_filt_uni);
        in_data  = (r_pos >= P_HDR) && (r_pos < P_LIMIT);
        emit     = in_data && n_hdr_ok && n_op_ok && passes;
        slot_pos = r_pos - P_HDR;
        n_ovf    = r_ovf || (r_pos >= P_LIMIT);
        n_pos    = (r_pos < P_LIMIT) ? r_pos + 1'b1 : r_pos;

        if (r_pos < P_HDR_M) begin
            status = artdmx_pkg::ST_SHORT;
        end else if (!n_hdr_ok) begin
            status = artdmx_pkg::ST_BAD_ID;
        end else if (!n_op_ok) begin
            status = artdmx_pkg::ST_OPCODE;
        end else if (!passes) begin
            status = artdmx_pkg::ST_FILTERED;
        end else begin
            status = artdmx_pkg::ST_OK;
        end

        cnt_raw = r_pos - P_HDR_M;
        cnt_sat = (r_pos < P_HDR) ? '0 : ((cnt_raw > P_MAX) ? P_MAX : cnt_raw);

        o_produce                = emit || i_last;
        o_result                 = '0;
        o_result.slot_valid      = emit;
        o_result.slot_index      = emit ? 9'(slot_pos) : 9'd0;
        o_result.slot_value      = emit ? i_byte : 8'd0;
        o_result.frame_end       = i_last;
        o_result.status          = i_last ? status : artdmx_pkg::ST_OK;
        o_result.universe        = n_uni;
        o_result.sequence_num    = n_seq;
        o_result.physical        = n_phy;
        if (i_last && status == artdmx_pkg::ST_OK) begin
            o_result.slot_count = 10'(cnt_sat);
            o_result.truncated  = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr_ok <= 1'b1;
            r_op_ok  <= 1'b1;
            r_ovf    <= 1'b0;
            r_uni    <= '0;
            r_seq    <= '0;
            r_phy    <= '0;
        end else if (i_fire) begin
            r_uni <= n_uni;
            r_seq <= n_seq;
            r_phy <= n_phy;
            if (i_last) begin
                r_pos    <= '0;
                r_hdr_ok <= 1'b1;
                r_op_ok  <= 1'b1;
                r_ovf    <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_hdr_ok <= n_hdr_ok;
                r_op_ok  <= n_op_ok;
                r_ovf    <= n_ovf;
            end
        end
    end

endmodule

FILE: design/artdmx_outreg.sv
// Result register with valid/stall handshake toward the consumer.
module artdmx_outreg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  artdmx_pkg::t_result  i_result,
    input  logic                 i_stall,
    output logic                 o_free,
    output logic                 o_valid,
    output artdmx_pkg::t_result  o_result
);

    logic                r_valid;
    artdmx_pkg::t_result r_result;

    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: design/artnet_dmx_packet_parser_core.sv
// Art-Net OpDmx receiver top level: input word register, parser and result register.
// Takes one UDP payload byte per cycle with a last-byte flag and sustains one word
// per clock while the result side does not stall; a result word is presented once
// its byte has passed the input register and the result register has taken the
// outcome. Bytes 0-6 must read "Art-Net" and bytes 8-9 opcode 0x5000; sequence,
// physical and universe are latched from bytes 12-15; data bytes from offset 18,
// up to MAX_SLOTS, come out as slots with their index when the packet passes its
// checks and the universe filter, and the last byte always gives one word carrying
// the packet status. Other header bytes produce no word. Stall from the result
// side reaches o_in_stall combinationally only while a byte that produces a word
// is held. Configuration writes are always taken and must be made while idle.
module artnet_dmx_packet_parser_core #(
    parameter int MAX_SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_slot_valid,
    output logic [8:0]  o_slot_index,
    output logic [7:0]  o_slot_value,
    output logic        o_frame_end,
    output logic [2:0]  o_packet_status,
    output logic [15:0] o_universe_out,
    output logic [7:0]  o_sequence_out,
    output logic [7:0]  o_physical_out,
    output logic [9:0]  o_slot_count,
    output logic        o_truncated
);

    logic        r_filt_en;
    logic [15:0] r_filt_uni;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic                produce;
    logic                out_free;
    logic                advance;
    logic                in_accept;
    artdmx_pkg::t_result res;
    artdmx_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_en  <= 1'b0;
            r_filt_uni <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                artdmx_pkg::CFG_FILTER_ENABLE:   r_filt_en  <= i_cfg_data[0];
                artdmx_pkg::CFG_FILTER_UNIVERSE: r_filt_uni <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!produce || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    artdmx_parse #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_filt_en  (r_filt_en),
        .i_filt_uni (r_filt_uni),
        .o_produce  (produce),
        .o_result   (res)
    );

    artdmx_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && produce),
        .i_result (res),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    assign o_slot_valid    = out_res.slot_valid;
    assign o_slot_index    = out_res.slot_index;
    assign o_slot_value    = out_res.slot_value;
    assign o_frame_end     = out_res.frame_end;
    assign o_packet_status = out_res.status;
    assign o_universe_out  = out_res.universe;
    assign o_sequence_out  = out_res.sequence_num;
    assign o_physical_out  = out_res.physical;
    assign o_slot_count    = out_res.slot_count;
    assign o_truncated     = out_res.truncated;

    a_word_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> o_slot_valid)
        else $error("result word with neither slot nor frame end");

    a_reject_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_status != artdmx_pkg::ST_OK
        |-> o_slot_count == 10'd0 && !o_truncated)
        else $error("rejected packet reports slot count");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_valid |-> 10'(o_slot_index) < 10'(MAX_SLOTS))
        else $error("slot index beyond MAX_SLOTS");

    a_trunc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_frame_end && o_slot_count == 10'(MAX_SLOTS))
        else $error("truncated packet without full slot count");

endmodule
